FILE: sv/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and constants for the JSON string escaper with UTF-8 check.
// ----------------------------------------------------------------------------
package jse_pkg;

    // Largest number of output beats that one input beat can cause.
    localparam int unsigned MAX_RUN = 8;

    // Characters that the escaper emits.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ERROR  = 8'h00;

    // Byte class boundaries.
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] LEAD2_LO    = 8'hc2;
    localparam logic [7:0] LEAD2_HI    = 8'hdf;
    localparam logic [7:0] LEAD3_LO    = 8'he0;
    localparam logic [7:0] LEAD3_HI    = 8'hef;
    localparam logic [7:0] LEAD4_LO    = 8'hf0;
    localparam logic [7:0] LEAD4_HI    = 8'hf4;

    // Code point limits for the sequence check.
    localparam logic [20:0] MIN_SCALAR3 = 21'h000800;
    localparam logic [20:0] MIN_SCALAR4 = 21'h010000;
    localparam logic [20:0] SURR_LO     = 21'h00d800;
    localparam logic [20:0] SURR_HI     = 21'h00dfff;
    localparam logic [20:0] MAX_SCALAR  = 21'h10ffff;

    // Sequence lengths.
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    // One queued run: the output beats that a single input beat causes.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] res_bytes;  // beat k in res_bytes[k]
        logic [3:0]              count;      // 1 .. MAX_RUN
        logic                    key_end;    // final beat closes the key
        logic                    bad;        // final beat is the error beat
    } run_desc_t;

    // Lower-case hexadecimal digit.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        r = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
        return r;
    endfunction

endpackage

FILE: sv/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Key state tracking and classification of each input beat into a run of
// output beats, handed on to the queue as one descriptor.
// ----------------------------------------------------------------------------
module jse_front
    import jse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic [7:0] key_byte,
    input  logic      last_byte,
    input  logic      empty_key,
    output logic      push,
    output run_desc_t desc
);

    logic        in_key_reg, in_key_next;
    logic        discard_reg, discard_next;
    logic [2:0]  seq_len_reg, seq_len_next;
    logic [2:0]  seq_seen_reg, seq_seen_next;
    logic [23:0] held_reg, held_next;
    logic [20:0] acc_reg, acc_next;

    // Classification and state update for one beat.
    always_comb
    begin
        logic              open_n;
        logic [3:0]        body_n;
        logic [MAX_RUN-1:0][7:0] body;
        logic              tail_n;
        logic [7:0]        tail_byte;
        logic              tail_end;
        logic              tail_bad;
        logic              fail;
        logic [20:0]       acc_new;
        logic [2:0]        seen_new;
        logic              range_bad;
        logic [3:0]        open_w;
        logic [3:0]        pos;

        in_key_next   = in_key_reg;
        discard_next  = discard_reg;
        seq_len_next  = seq_len_reg;
        seq_seen_next = seq_seen_reg;
        held_next     = held_reg;
        acc_next      = acc_reg;
        open_n    = 1'b0;
        body_n    = 4'd0;
        body      = '0;
        tail_n    = 1'b0;
        tail_byte = CH_QUOTE;
        tail_end  = 1'b0;
        tail_bad  = 1'b0;
        fail      = 1'b0;
        acc_new   = {acc_reg[14:0], key_byte[5:0]};
        seen_new  = seq_seen_reg + 3'd1;
        range_bad = 1'b0;

        if (empty_key)
        begin
            if (discard_reg)
            begin
                discard_next = 1'b0;
            end
            else if (in_key_reg)
            begin
                // Close the key; a pending sequence is truncated.
                tail_n      = 1'b1;
                tail_end    = 1'b1;
                in_key_next = 1'b0;
                if (seq_len_reg != SEQ_NONE)
                begin
                    tail_byte     = CH_ERROR;
                    tail_bad      = 1'b1;
                    seq_len_next  = SEQ_NONE;
                    seq_seen_next = 3'd0;
                    held_next     = '0;
                    acc_next      = '0;
                end
            end
            else
            begin
                open_n   = 1'b1;
                tail_n   = 1'b1;
                tail_end = 1'b1;
            end
        end
        else if (discard_reg)
        begin
            if (last_byte)
            begin
                discard_next = 1'b0;
            end
        end
        else
        begin
            open_n      = !in_key_reg;
            in_key_next = 1'b1;

            if (seq_len_reg == SEQ_NONE)
            begin
                // Start of a character.
                if (key_byte < ASCII_LIMIT)
                begin
                    if (key_byte == CH_QUOTE || key_byte == CH_BSLASH)
                    begin
                        body[0] = CH_BSLASH;
                        body[1] = key_byte;
                        body_n  = 4'd2;
                    end
                    else if (key_byte < CTRL_LIMIT)
                    begin
                        body[0] = CH_BSLASH;
                        body[1] = CH_U;
                        body[2] = CH_ZERO;
                        body[3] = CH_ZERO;
                        body[4] = hex_char(key_byte[7:4]);
                        body[5] = hex_char(key_byte[3:0]);
                        body_n  = 4'd6;
                    end
                    else
                    begin
                        body[0] = key_byte;
                        body_n  = 4'd1;
                    end
                end
                else if (key_byte >= LEAD2_LO && key_byte <= LEAD2_HI)
                begin
                    seq_len_next = SEQ_TWO;
                    acc_next     = {16'h0, key_byte[4:0]};
                end
                else if (key_byte >= LEAD3_LO && key_byte <= LEAD3_HI)
                begin
                    seq_len_next = SEQ_THREE;
                    acc_next     = {17'h0, key_byte[3:0]};
                end
                else if (key_byte >= LEAD4_LO && key_byte <= LEAD4_HI)
                begin
                    seq_len_next = SEQ_FOUR;
                    acc_next     = {18'h0, key_byte[2:0]};
                end
                else
                begin
                    fail = 1'b1;
                end
                if (seq_len_next != SEQ_NONE)
                begin
                    seq_seen_next = 3'd1;
                    held_next     = {16'h0, key_byte};
                end
            end
            else if (key_byte[7:6] != 2'b10)
            begin
                fail = 1'b1;
            end
            else if (seen_new < seq_len_reg)
            begin
                // Continuation byte, sequence not yet complete.
                seq_seen_next = seen_new;
                acc_next      = acc_new;
                case (seq_seen_reg)
                    3'd1:    held_next[15:8]  = key_byte;
                    3'd2:    held_next[23:16] = key_byte;
                    default: held_next        = held_reg;
                endcase
            end
            else
            begin
                // Sequence complete: range check, then emit it unchanged.
                range_bad = (seq_len_reg == SEQ_THREE && acc_new < MIN_SCALAR3) ||
                            (seq_len_reg == SEQ_FOUR && acc_new < MIN_SCALAR4) ||
                            (acc_new >= SURR_LO && acc_new <= SURR_HI) ||
                            (acc_new > MAX_SCALAR);
                if (range_bad)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    body[0] = held_reg[7:0];
                    body[1] = (seq_len_reg == SEQ_TWO) ? key_byte : held_reg[15:8];
                    body[2] = (seq_len_reg == SEQ_THREE) ? key_byte : held_reg[23:16];
                    body[3] = key_byte;
                    body_n  = {1'b0, seq_len_reg};
                    seq_len_next  = SEQ_NONE;
                    seq_seen_next = 3'd0;
                    held_next     = '0;
                    acc_next      = '0;
                end
            end

            if (fail)
            begin
                tail_n        = 1'b1;
                tail_byte     = CH_ERROR;
                tail_end      = 1'b1;
                tail_bad      = 1'b1;
                in_key_next   = 1'b0;
                discard_next  = !last_byte;
                seq_len_next  = SEQ_NONE;
                seq_seen_next = 3'd0;
                held_next     = '0;
                acc_next      = '0;
            end
            else if (last_byte)
            begin
                tail_n      = 1'b1;
                tail_end    = 1'b1;
                in_key_next = 1'b0;
                if (seq_len_next != SEQ_NONE)
                begin
                    tail_byte     = CH_ERROR;
                    tail_bad      = 1'b1;
                    seq_len_next  = SEQ_NONE;
                    seq_seen_next = 3'd0;
                    held_next     = '0;
                    acc_next      = '0;
                end
            end
        end

        // Pack opening quote, body and tail into consecutive beats.
        open_w = {3'b000, open_n};
        for (int i = 0; i < MAX_RUN; i++)
        begin
            pos = 4'(i);
            if (pos < open_w)
            begin
                desc.res_bytes[i] = CH_QUOTE;
            end
            else if (pos < open_w + body_n)
            begin
                desc.res_bytes[i] = body[3'(pos - open_w)];
            end
            else
            begin
                desc.res_bytes[i] = tail_byte;
            end
        end
        desc.count   = open_w + body_n + {3'b000, tail_n};
        desc.key_end = tail_end;
        desc.bad     = tail_bad;
        push         = accept && (desc.count != 4'd0);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_key_reg   <= 1'b0;
            discard_reg  <= 1'b0;
            seq_len_reg  <= SEQ_NONE;
            seq_seen_reg <= 3'd0;
            held_reg     <= '0;
            acc_reg      <= '0;
        end
        else if (accept)
        begin
            in_key_reg   <= in_key_next;
            discard_reg  <= discard_next;
            seq_len_reg  <= seq_len_next;
            seq_seen_reg <= seq_seen_next;
            held_reg     <= held_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

FILE: sv/jse_queue.sv
// ----------------------------------------------------------------------------
// jse_queue
// Small first-in first-out queue of run descriptors between the front and
// back parts.
// ----------------------------------------------------------------------------
module jse_queue
    import jse_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  run_desc_t push_desc,
    output logic      full,
    input  logic      pop,
    output run_desc_t head_desc,
    output logic      head_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_desc_t        store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_desc  = store_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

FILE: sv/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Output sequencer: takes one run descriptor at a time and sends its beats
// one per cycle, while out_stall is low, on the output channel.
// ----------------------------------------------------------------------------
module jse_back
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  run_desc_t  head_desc,
    input  logic       head_valid,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       key_last,
    output logic       bad_utf8
);

    run_desc_t  cur_reg;
    logic [2:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       last_of_run;
    logic       fire;
    logic       done;

    assign last_of_run = (idx_reg == 3'(cur_reg.count - 4'd1));
    assign fire        = busy_reg && !out_stall;
    assign done        = fire && last_of_run;
    assign pop         = head_valid && (!busy_reg || done);

    assign out_valid = busy_reg;
    assign out_byte  = cur_reg.res_bytes[idx_reg];
    assign run_last  = last_of_run;
    assign key_last  = last_of_run && cur_reg.key_end;
    assign bad_utf8  = last_of_run && cur_reg.bad;

    // Beat index and busy flag.
    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            idx_next  = 3'd0;
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 3'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    // Current run payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_desc;
        end
    end

endmodule

FILE: sv/json_string_escaper_utf8_check.sv
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_check
// Emits each key as a quoted JSON string, escaping quote, backslash and
// control bytes and passing only well-formed UTF-8. An input beat is taken
// every cycle while the run queue has room; each beat yields from zero to
// eight output beats, sent one per cycle while out_stall is low, so the
// sustained rate is set by the output port. A run queue of QUEUE_DEPTH
// entries lets the input side run ahead of a stalled output. A rejected key
// ends in one error beat (bad_utf8 high, out_byte zero); the remaining bytes
// of that key are dropped. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module json_string_escaper_utf8_check
    import jse_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] key_byte,
    input  logic       last_byte,
    input  logic       empty_key,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       key_last,
    output logic       bad_utf8
);

    logic      accept;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    run_desc_t front_desc;
    run_desc_t head_desc;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Front part: key state and classification.
    jse_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .key_byte  (key_byte),
        .last_byte (last_byte),
        .empty_key (empty_key),
        .push      (q_push),
        .desc      (front_desc)
    );

    // Run queue.
    jse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (front_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_desc  (head_desc),
        .head_valid (q_valid)
    );

    // Back part: output sequencer.
    jse_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_desc  (head_desc),
        .head_valid (q_valid),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .key_last   (key_last),
        .bad_utf8   (bad_utf8)
    );

    // An error beat closes the key, ends the run and carries a zero byte.
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_utf8 |-> key_last && run_last && (out_byte == CH_ERROR))
        else $error("error beat malformed");

    // A key only ends on the final beat of a run.
    a_key_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_last |-> run_last)
        else $error("key end before end of run");

    // A run is sent without gaps once started.
    a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("gap inside a run");

    // A queued run is never lost to a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

endmodule

FILE: tb/json_string_escaper_utf8_check_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_check_tb
// Drives keys through the escaper as byte beats: first a directed set that
// covers every byte class, some UTF-8 failures and the empty-key cases,
// then random keys built mostly from well-formed elements. A scoreboard
// predicts every output beat and compares each one as it leaves the block.
// ----------------------------------------------------------------------------
module json_string_escaper_utf8_check_tb;
    import jse_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";

    // One predicted output beat.
    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       key_end;
        logic       bad;
    } esc_beat_t;

    // Predicts the escaped stream and checks each output beat against it.
    class escape_scoreboard;
        esc_beat_t   expected_beats[$];
        int          failures;
        logic        in_key;
        logic        discarding;
        logic [2:0]  seq_len;
        logic [2:0]  seq_cnt;
        logic [31:0] held;
        logic [20:0] scalar;

        function new();
            failures   = 0;
            in_key     = 1'b0;
            discarding = 1'b0;
            clear_seq();
        endfunction

        function void clear_seq();
            seq_len = SEQ_NONE;
            seq_cnt = 3'd0;
            held    = 32'h0;
            scalar  = 21'h0;
        endfunction

        function void emit(logic [7:0] ch, logic key_end, logic bad);
            esc_beat_t b;
            b.ch      = ch;
            b.run_end = 1'b0;
            b.key_end = key_end;
            b.bad     = bad;
            expected_beats.push_back(b);
        endfunction

        function logic [7:0] hex_digit(logic [3:0] v);
            return HEX_DIGITS[8 * (15 - v) +: 8];
        endfunction

        function void reject(logic more_follow);
            emit(CH_ERROR, 1'b1, 1'b1);
            clear_seq();
            in_key     = 1'b0;
            discarding = more_follow;
        endfunction

        function void close_key();
            if (seq_len != SEQ_NONE)
                reject(1'b0);
            else
            begin
                emit(CH_QUOTE, 1'b1, 1'b0);
                in_key = 1'b0;
            end
        endfunction

        // Returns 0 when the byte makes the key invalid.
        function bit absorb_byte(logic [7:0] c);
            if (seq_len == SEQ_NONE)
            begin
                if (c < ASCII_LIMIT)
                begin
                    if (c == CH_QUOTE || c == CH_BSLASH)
                    begin
                        emit(CH_BSLASH, 1'b0, 1'b0);
                        emit(c, 1'b0, 1'b0);
                    end
                    else if (c < CTRL_LIMIT)
                    begin
                        emit(CH_BSLASH, 1'b0, 1'b0);
                        emit(CH_U, 1'b0, 1'b0);
                        emit(CH_ZERO, 1'b0, 1'b0);
                        emit(CH_ZERO, 1'b0, 1'b0);
                        emit(hex_digit(c[7:4]), 1'b0, 1'b0);
                        emit(hex_digit(c[3:0]), 1'b0, 1'b0);
                    end
                    else
                        emit(c, 1'b0, 1'b0);
                    return 1'b1;
                end
                if (c >= LEAD2_LO && c <= LEAD2_HI)
                    seq_len = SEQ_TWO;
                else if (c >= LEAD3_LO && c <= LEAD3_HI)
                    seq_len = SEQ_THREE;
                else if (c >= LEAD4_LO && c <= LEAD4_HI)
                    seq_len = SEQ_FOUR;
                else
                    return 1'b0;
                seq_cnt = 3'd1;
                held    = {24'h0, c};
                scalar  = {13'h0, c & (8'h7f >> seq_len)};
                return 1'b1;
            end
            if (c[7:6] != 2'b10)
                return 1'b0;
            held    = held | ({24'h0, c} << (8 * seq_cnt[1:0]));
            scalar  = {scalar[14:0], c[5:0]};
            seq_cnt = seq_cnt + 3'd1;
            if (seq_cnt < seq_len)
                return 1'b1;
            if ((seq_len == SEQ_THREE && scalar < MIN_SCALAR3) ||
                (seq_len == SEQ_FOUR && scalar < MIN_SCALAR4) ||
                (scalar >= SURR_LO && scalar <= SURR_HI) ||
                scalar > MAX_SCALAR)
                return 1'b0;
            for (int k = 0; k < seq_len; k++)
                emit(held[8 * k +: 8], 1'b0, 1'b0);
            clear_seq();
            return 1'b1;
        endfunction

        // Notes one accepted input beat and queues the output it causes.
        function void predict_beat(logic [7:0] b, logic last, logic empty);
            int        before_cnt;
            esc_beat_t tail;
            before_cnt = expected_beats.size();
            if (empty)
            begin
                if (discarding)
                    discarding = 1'b0;
                else if (in_key)
                    close_key();
                else
                begin
                    emit(CH_QUOTE, 1'b0, 1'b0);
                    emit(CH_QUOTE, 1'b1, 1'b0);
                end
            end
            else if (discarding)
            begin
                if (last)
                    discarding = 1'b0;
            end
            else
            begin
                if (!in_key)
                begin
                    emit(CH_QUOTE, 1'b0, 1'b0);
                    in_key = 1'b1;
                end
                if (!absorb_byte(b))
                    reject(!last);
                else if (last)
                    close_key();
            end
            if (expected_beats.size() > before_cnt)
            begin
                tail = expected_beats.pop_back();
                tail.run_end = 1'b1;
                expected_beats.push_back(tail);
            end
        endfunction

        // Compares one accepted output beat with the oldest prediction.
        function void check_beat(logic [7:0] ob, logic rl, logic kl, logic bu);
            esc_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected output beat: out_byte %h", ob);
                failures++;
                return;
            end
            want = expected_beats.pop_front();
            if (ob !== want.ch)
            begin
                $error("out_byte: expected %h, got %h", want.ch, ob);
                failures++;
            end
            if (rl !== want.run_end)
            begin
                $error("run_last: expected %b, got %b", want.run_end, rl);
                failures++;
            end
            if (kl !== want.key_end)
            begin
                $error("key_last: expected %b, got %b", want.key_end, kl);
                failures++;
            end
            if (bu !== want.bad)
            begin
                $error("bad_utf8: expected %b, got %b", want.bad, bu);
                failures++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] key_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       empty_key = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       key_last;
    logic       bad_utf8;

    escape_scoreboard sb;
    int unsigned      send_idle_pct = 6;
    int unsigned      recv_stall_pct = 80;
    int unsigned      beats_sent = 0;
    int unsigned      cycle_count = 0;
    logic [7:0]       key_bytes[$];

    json_string_escaper_utf8_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .key_byte  (key_byte),
        .last_byte (last_byte),
        .empty_key (empty_key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .key_last  (key_last),
        .bad_utf8  (bad_utf8)
    );

    always #1 clk = ~clk;

    // Note accepted input beats before checking output beats of the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.predict_beat(key_byte, last_byte, empty_key);
            if (out_valid && !out_stall)
                sb.check_beat(out_byte, run_last, key_last, bad_utf8);
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Ends the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[json_string_escaper_utf8_check] ERROR");
        $finish;
    end

    // Offers one beat, idling at random first, and returns once it is taken.
    task automatic send_beat(input logic [7:0] b, input logic last, input logic empty);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        key_byte  <= b;
        last_byte <= last;
        empty_key <= empty;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // Sends the bytes of key_bytes as one key, closed by the last flag or by
    // an empty-key beat; no bytes at all makes an empty key.
    task automatic send_bytes(input bit end_by_empty);
        if (key_bytes.size() == 0)
            send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        else
        begin
            foreach (key_bytes[i])
                send_beat(key_bytes[i], !end_by_empty && i == key_bytes.size() - 1, 1'b0);
            if (end_by_empty)
                send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end
    endtask

    // Holds the sender until every predicted beat has come out.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Appends an n-byte UTF-8 form of cp, minimal or not.
    function automatic void push_utf8(input logic [20:0] cp, input int n);
        case (n)
            2:
            begin
                key_bytes.push_back({3'b110, cp[10:6]});
                key_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                key_bytes.push_back({4'b1110, cp[15:12]});
                key_bytes.push_back({2'b10, cp[11:6]});
                key_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                key_bytes.push_back({5'b11110, cp[20:18]});
                key_bytes.push_back({2'b10, cp[17:12]});
                key_bytes.push_back({2'b10, cp[11:6]});
                key_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Appends one well-formed character of a random class.
    function automatic void add_good_char();
        int unsigned pick;
        logic [20:0] cp;
        int          n;
        pick = $urandom_range(99);
        if (pick < 40)
            key_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
        else if (pick < 50)
            key_bytes.push_back($urandom_range(1) ? CH_QUOTE : CH_BSLASH);
        else if (pick < 60)
            key_bytes.push_back($urandom_range(3) == 0 ? 8'h7f : 8'($urandom_range(8'h1f)));
        else
        begin
            n = $urandom_range(2, 4);
            if (n == 2)
                cp = 21'($urandom_range(21'h80, 21'h7ff));
            else if (n == 3)
            begin
                cp = 21'($urandom_range(MIN_SCALAR3, 21'hffff));
                if (cp >= SURR_LO && cp <= SURR_HI)
                    cp = cp + 21'h800;
            end
            else
                cp = 21'($urandom_range(MIN_SCALAR4, MAX_SCALAR));
            push_utf8(cp, n);
        end
    endfunction

    // Appends one element that makes the key invalid.
    function automatic void add_bad_char();
        logic [7:0] lead;
        logic [7:0] b;
        int         conts;
        case ($urandom_range(6))
            0:
                key_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hc1))
                                                      : 8'($urandom_range(8'hf5, 8'hff)));
            1:
            begin
                // Broken continuation somewhere inside a sequence.
                lead = 8'($urandom_range(LEAD2_LO, LEAD4_HI));
                conts = (lead >= LEAD4_LO) ? 3 : (lead >= LEAD3_LO) ? 2 : 1;
                key_bytes.push_back(lead);
                repeat ($urandom_range(conts - 1))
                    key_bytes.push_back({2'b10, 6'($urandom_range(63))});
                b = 8'($urandom_range(255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                key_bytes.push_back(b);
            end
            2: push_utf8(21'($urandom_range(21'h7ff)), 3);
            3: push_utf8(21'($urandom_range(21'hffff)), 4);
            4: push_utf8(21'($urandom_range(SURR_LO, SURR_HI)), 3);
            5: push_utf8(21'($urandom_range(21'h110000, 21'h13ffff)), 4);
            default:
            begin
                // Sequence cut short: a lead with too few continuations.
                lead = 8'($urandom_range(LEAD2_LO, LEAD4_HI));
                conts = (lead >= LEAD4_LO) ? 3 : (lead >= LEAD3_LO) ? 2 : 1;
                key_bytes.push_back(lead);
                repeat ($urandom_range(conts - 1))
                    key_bytes.push_back({2'b10, 6'($urandom_range(63))});
            end
        endcase
    endfunction

    // One random key: mostly well formed, sometimes with one fault, now and
    // then followed by a stray beat of random content.
    task automatic send_random_key();
        int n;
        int bad_at;
        n = $urandom_range(6);
        bad_at = ($urandom_range(99) < 25) ? int'($urandom_range(n)) : -1;
        key_bytes.delete();
        for (int i = 0; i <= n; i++)
        begin
            if (i == bad_at)
                add_bad_char();
            if (i < n)
                add_good_char();
        end
        send_bytes($urandom_range(99) < 15);
        if ($urandom_range(99) < 5)
            send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    initial
    begin
        sb = new();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed keys: empty, every ASCII class, shortest and largest
        // sequences, and some of the ways a key can be rejected or cut off.
        key_bytes = {};
        send_bytes(1'b0);
        key_bytes = '{8'h00, 8'h1f, 8'h22, 8'h5c, 8'h7f, 8'h41};
        send_bytes(1'b0);
        key_bytes = '{8'hc2, 8'h80};
        send_bytes(1'b0);
        key_bytes = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_bytes(1'b0);
        key_bytes = '{8'h80, 8'h41};
        send_bytes(1'b0);
        key_bytes = '{8'he0, 8'h9f, 8'hbf};
        send_bytes(1'b0);
        key_bytes = '{8'hc2, 8'h41};
        send_bytes(1'b0);
        key_bytes = '{8'he0, 8'ha0};
        send_bytes(1'b0);
        key_bytes = '{8'hc2};
        send_bytes(1'b1);
        key_bytes = '{8'h41};
        send_bytes(1'b1);
        key_bytes = '{8'hff};
        send_bytes(1'b1);

        // Random keys: slow receiver first, then slow sender, then full rate.
        while (beats_sent < 150)
            send_random_key();
        wait_for_results();
        send_idle_pct  = 80;
        recv_stall_pct = 6;
        while (beats_sent < 280)
            send_random_key();
        wait_for_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (beats_sent < 410)
            send_random_key();

        wait_for_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[json_string_escaper_utf8_check] OK");
        else
            $display("[json_string_escaper_utf8_check] ERROR");
        $finish;
    end

endmodule
